### src/lagged_fibonacci_fraction_generator_defines.svh
// Assertion macros used by the checker file.
`ifndef LAGGED_FIBONACCI_FRACTION_GENERATOR_DEFINES_SVH
`define LAGGED_FIBONACCI_FRACTION_GENERATOR_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define LFFG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define LFFG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### src/lffg_pkg.sv
// Types and constants for the lagged Fibonacci fraction generator.
package lffg_pkg;
    localparam int LongLag = 100;
    localparam int ShortLag = 37;
    localparam int LagGap = LongLag - ShortLag;
    localparam int FracBits = 52;
    localparam int SeedBits = 30;
    localparam int ScratchLen = 2 * LongLag - 1;
    localparam int WarmupSteps = 10 * ScratchLen;
    localparam int RingAw = 7;
    localparam int ScrAw = 8;
    localparam logic [SeedBits-1:0] DefaultStream = 30'd314159;
    localparam logic [FracBits-1:0] FracMax = {FracBits{1'b1}};

    typedef struct packed {
        logic                mode;
        logic [SeedBits-1:0] seed_value;
    } t_req;

    typedef struct packed {
        logic [FracBits-1:0] fraction;
        logic                seed_ack;
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BOOT,
        S_SQ_MOVE_RD,
        S_SQ_MOVE_WR,
        S_SQ_ZERO,
        S_RED_RD,
        S_RED_A_RD,
        S_RED_A_WR,
        S_RED_B_RD,
        S_RED_B_WR,
        S_SH_RD,
        S_SH_WR,
        S_SH_TOP_RD,
        S_SH_TOP_WR,
        S_SH_37_RD,
        S_SH_37_WR,
        S_LOAD_RD,
        S_LOAD_WR,
        S_WARM_A,
        S_WARM_B,
        S_NEXT_A,
        S_NEXT_B,
        S_DONE
    } t_state;

    // Ring access request from the sequencer to the ring memory.
    typedef struct packed {
        logic              we;
        logic [RingAw-1:0] waddr;
        logic [FracBits-1:0] wdata;
        logic [RingAw-1:0] raddr_a;
        logic [RingAw-1:0] raddr_b;
    } t_ring_ctl;
endpackage

### src/lffg_ring_mem.sv
// 100-word lag ring: one write port and two registered read ports.
module lffg_ring_mem
    import lffg_pkg::*;
(
    input  logic                i_clk,
    input  t_ring_ctl           i_ctl,
    output logic [FracBits-1:0] o_rdata_a,
    output logic [FracBits-1:0] o_rdata_b
);
    logic [FracBits-1:0] r_mem [LongLag];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        o_rdata_a <= r_mem[i_ctl.raddr_a];
        o_rdata_b <= r_mem[i_ctl.raddr_b];
    end
endmodule

### src/lffg_scratch_mem.sv
// 199-word seeding scratch memory: one write port, one registered read port.
module lffg_scratch_mem
    import lffg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ScrAw-1:0]    i_waddr,
    input  logic [FracBits-1:0] i_wdata,
    input  logic [ScrAw-1:0]    i_raddr,
    output logic [FracBits-1:0] o_rdata
);
    logic [FracBits-1:0] r_mem [ScratchLen];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### src/lagged_fibonacci_fraction_generator.sv
// Top level: seeding sequencer and lag ring for the fraction generator.
// A next request (mode 0) raises the o_valid strobe after one ring read of
// the oldest word and its partner 63 places later, then the write-back of
// their sum. A reseed request runs the whole stream-start procedure through
// the scratch memory one step a cycle: the bootstrap fill of 100 words, then
// 69 plus the seed's bit length squaring rounds, each 1 bit of the seed
// adding a shift by z. After that come the ring load and 1990 warm-up
// steps. A next request before any seed runs that procedure first with
// stream 314159. busy is high from acceptance until the result strobe; the
// result is shown for exactly one cycle and cannot be stalled.
module lagged_fibonacci_fraction_generator
    import lffg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_res o_res
);
    t_state r_state, n_state;
    logic [SeedBits-1:0] r_bits, n_bits;
    logic [6:0]  r_rounds, n_rounds;
    logic [ScrAw-1:0] r_j, n_j;
    logic [10:0] r_cnt, n_cnt;
    logic [RingAw-1:0] r_head, n_head;
    logic r_seeded, n_seeded;
    logic r_ack, n_ack;
    logic [FracBits-1:0] r_walk, n_walk;
    logic [FracBits-1:0] r_hold, n_hold;
    logic [FracBits-1:0] r_out, n_out;
    logic r_valid, n_valid;

    t_ring_ctl ring_ctl;
    logic [FracBits-1:0] ring_a, ring_b;
    logic sc_we;
    logic [ScrAw-1:0] sc_waddr, sc_raddr;
    logic [FracBits-1:0] sc_wdata, sc_rdata;
    logic [FracBits:0] walk2;
    logic [RingAw-1:0] partner_sum, head_inc;

    lffg_ring_mem u_ring (
        .i_clk    (i_clk),
        .i_ctl    (ring_ctl),
        .o_rdata_a(ring_a),
        .o_rdata_b(ring_b)
    );

    lffg_scratch_mem u_scr (
        .i_clk  (i_clk),
        .i_we   (sc_we),
        .i_waddr(sc_waddr),
        .i_wdata(sc_wdata),
        .i_raddr(sc_raddr),
        .o_rdata(sc_rdata)
    );

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res.fraction = r_out;
    assign o_res.seed_ack = r_ack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0;
            r_seeded <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head;
            r_seeded <= n_seeded;
            r_valid <= n_valid;
        end
        r_bits <= n_bits;
        r_rounds <= n_rounds;
        r_j <= n_j;
        r_cnt <= n_cnt;
        r_ack <= n_ack;
        r_walk <= n_walk;
        r_hold <= n_hold;
        r_out <= n_out;
    end

    always_comb begin
        walk2 = {r_walk, 1'b0};
        partner_sum = (r_head >= RingAw'(ShortLag)) ? r_head - RingAw'(ShortLag)
                                                     : r_head + RingAw'(LagGap);
        head_inc = (r_head == RingAw'(LongLag - 1)) ? '0 : r_head + 1'b1;
    end

    always_comb begin
        n_state = r_state;
        n_bits = r_bits;
        n_rounds = r_rounds;
        n_j = r_j;
        n_cnt = r_cnt;
        n_head = r_head;
        n_seeded = r_seeded;
        n_ack = r_ack;
        n_walk = r_walk;
        n_hold = r_hold;
        n_out = r_out;
        n_valid = 1'b0;
        ring_ctl = '0;
        ring_ctl.raddr_a = r_head;
        ring_ctl.raddr_b = partner_sum;
        sc_we = 1'b0;
        sc_waddr = r_j;
        sc_wdata = '0;
        sc_raddr = r_j;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_req.mode || !r_seeded) begin
                        n_bits = i_req.mode ? i_req.seed_value : DefaultStream;
                        n_walk = FracBits'({21'd0, n_bits, 1'b0}) + FracBits'(4);
                        n_ack = i_req.mode;
                        n_rounds = 7'd69;
                        n_j = '0;
                        n_state = S_BOOT;
                    end else begin
                        n_ack = 1'b0;
                        n_state = S_NEXT_A;
                    end
                end
            end
            S_BOOT: begin
                // j = 1 gets the extra +1 at its write.
                sc_we = 1'b1;
                sc_wdata = (r_j == ScrAw'(1)) ? r_walk + 1'b1 : r_walk;
                n_walk = walk2[FracBits] ? walk2[FracBits-1:0] + FracBits'(2)
                                         : walk2[FracBits-1:0];
                if (r_j == ScrAw'(LongLag - 1)) begin
                    n_j = ScrAw'(LongLag - 1);
                    n_state = S_SQ_MOVE_RD;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            // Squaring spread: sc[2j] = sc[j], sc[2j-1] = 0 for j = 99..1.
            S_SQ_MOVE_RD: begin
                sc_raddr = r_j;
                n_state = S_SQ_MOVE_WR;
            end
            S_SQ_MOVE_WR: begin
                sc_we = 1'b1;
                sc_waddr = {r_j[ScrAw-2:0], 1'b0};
                sc_wdata = sc_rdata;
                n_state = S_SQ_ZERO;
            end
            S_SQ_ZERO: begin
                sc_we = 1'b1;
                sc_waddr = {r_j[ScrAw-2:0], 1'b0} - 1'b1;
                if (r_j == ScrAw'(1)) begin
                    n_j = ScrAw'(ScratchLen - 1);
                    n_state = S_RED_RD;
                end else begin
                    n_j = r_j - 1'b1;
                    n_state = S_SQ_MOVE_RD;
                end
            end
            // Reduction: fold sc[j] into sc[j-63] and sc[j-100], j = 198..100.
            S_RED_RD: begin
                sc_raddr = r_j;
                n_state = S_RED_A_RD;
            end
            S_RED_A_RD: begin
                n_hold = sc_rdata;
                sc_raddr = r_j - ScrAw'(LagGap);
                n_state = S_RED_A_WR;
            end
            S_RED_A_WR: begin
                sc_we = 1'b1;
                sc_waddr = r_j - ScrAw'(LagGap);
                sc_wdata = sc_rdata + r_hold;
                n_state = S_RED_B_RD;
            end
            S_RED_B_RD: begin
                sc_raddr = r_j - ScrAw'(LongLag);
                n_state = S_RED_B_WR;
            end
            S_RED_B_WR: begin
                sc_we = 1'b1;
                sc_waddr = r_j - ScrAw'(LongLag);
                sc_wdata = sc_rdata + r_hold;
                if (r_j == ScrAw'(LongLag)) begin
                    if (r_bits[0]) begin
                        n_j = ScrAw'(LongLag - 1);
                        n_state = S_SH_RD;
                    end else begin
                        n_state = S_SH_TOP_WR;
                        n_j = '0;
                    end
                end else begin
                    n_j = r_j - 1'b1;
                    n_state = S_RED_RD;
                end
            end
            // Multiply by z: shift sc[0..99] up one, then wrap sc[100].
            S_SH_RD: begin
                sc_raddr = r_j;
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                sc_we = 1'b1;
                sc_waddr = r_j + 1'b1;
                sc_wdata = sc_rdata;
                if (r_j == '0) begin
                    n_state = S_SH_TOP_RD;
                end else begin
                    n_j = r_j - 1'b1;
                    n_state = S_SH_RD;
                end
            end
            S_SH_TOP_RD: begin
                sc_raddr = ScrAw'(LongLag);
                n_state = S_SH_37_RD;
            end
            S_SH_37_RD: begin
                n_hold = sc_rdata;
                sc_we = 1'b1;
                sc_waddr = '0;
                sc_wdata = sc_rdata;
                sc_raddr = ScrAw'(ShortLag);
                n_state = S_SH_37_WR;
            end
            S_SH_37_WR: begin
                sc_we = 1'b1;
                sc_waddr = ScrAw'(ShortLag);
                sc_wdata = sc_rdata + r_hold;
                n_state = S_SH_TOP_WR;
            end
            // End of one round: advance the exponent bits or count down.
            S_SH_TOP_WR: begin
                if (r_bits != '0) begin
                    n_bits = r_bits >> 1;
                end else begin
                    n_rounds = r_rounds - 1'b1;
                end
                if (r_bits == '0 && r_rounds == 7'd1) begin
                    n_j = '0;
                    n_state = S_LOAD_RD;
                end else begin
                    n_j = ScrAw'(LongLag - 1);
                    n_state = S_SQ_MOVE_RD;
                end
            end
            S_LOAD_RD: begin
                sc_raddr = r_j;
                n_state = S_LOAD_WR;
            end
            S_LOAD_WR: begin
                ring_ctl.we = 1'b1;
                ring_ctl.waddr = (r_j < ScrAw'(ShortLag))
                    ? RingAw'(r_j + ScrAw'(LagGap)) : RingAw'(r_j - ScrAw'(ShortLag));
                ring_ctl.wdata = sc_rdata;
                if (r_j == ScrAw'(LongLag - 1)) begin
                    n_head = '0;
                    n_cnt = '0;
                    n_state = S_WARM_A;
                end else begin
                    n_j = r_j + 1'b1;
                    n_state = S_LOAD_RD;
                end
            end
            S_WARM_A: begin
                n_state = S_WARM_B;
            end
            S_WARM_B: begin
                ring_ctl.we = 1'b1;
                ring_ctl.waddr = r_head;
                ring_ctl.wdata = ring_a + ring_b;
                n_head = head_inc;
                if (r_cnt == 11'(WarmupSteps - 1)) begin
                    n_seeded = 1'b1;
                    if (r_ack) begin
                        n_out = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_NEXT_A;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    n_state = S_WARM_A;
                end
            end
            S_NEXT_A: begin
                n_state = S_NEXT_B;
            end
            S_NEXT_B: begin
                ring_ctl.we = 1'b1;
                ring_ctl.waddr = r_head;
                ring_ctl.wdata = ring_a + ring_b;
                n_head = head_inc;
                n_out = ring_a;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

### src/lffg_checker.sv
// Port-level checker for the fraction generator, bound to the top level.
`include "lagged_fibonacci_fraction_generator_defines.svh"
module lffg_checker
    import lffg_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input t_res o_res
);
    `LFFG_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept raises busy")
    `LFFG_ASSERT_NEXT(a_strobe_one, i_clk, i_rst_n, o_valid, !o_valid, "strobe is one cycle")
    `LFFG_ASSERT_SAME(a_ack_zero, i_clk, i_rst_n, o_valid && o_res.seed_ack, o_res.fraction == '0, "ack is zero")
    `LFFG_ASSERT_SAME(a_strobe_busy, i_clk, i_rst_n, o_valid, busy == 1'b0, "strobe only when done")
endmodule

bind lagged_fibonacci_fraction_generator lffg_checker u_lffg_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_valid(o_valid),
    .o_res  (o_res)
);
